FILE: src/smacc_pkg.sv
// Shared types, constants and saturation helpers for the sparse MTTKRP accumulator.
`default_nettype none

package smacc_pkg;

    localparam int MAX_MODES = 4;
    localparam int MAX_ROWS  = 1024;
    localparam int MAX_RANK  = 16;

    localparam int MODE_W   = $clog2(MAX_MODES);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int COL_W    = $clog2(MAX_RANK);
    localparam int FADDR_W  = MODE_W + ROW_W + COL_W;
    localparam int AADDR_W  = ROW_W + COL_W;
    localparam int DATA_W   = 32;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_PROC  = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        REG_NUM_MODES   = 2'd0,
        REG_RANK        = 2'd1,
        REG_TARGET_MODE = 2'd2,
        REG_NONE        = 2'd3
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COL,
        ST_MODE,
        ST_FMUL,
        ST_FSAT,
        ST_ARD,
        ST_AWR,
        ST_RRD,
        ST_RCAP,
        ST_OUT
    } state_t;

    // control from the sequencer to the shared multiplier
    typedef struct packed {
        logic mul_en;
    } mul_ctrl_t;

    typedef struct packed {
        logic [DATA_W-1:0] val;
        logic              sat;
    } sat_t;

    // clip a 48-bit signed value into the 32-bit range
    function automatic sat_t clip48(input logic [47:0] v);
        sat_t r;
        r.sat = 1'b0;
        r.val = v[31:0];
        if (!v[47] && (|v[46:31])) begin
            r.sat = 1'b1;
            r.val = 32'h7FFF_FFFF;
        end else if (v[47] && !(&v[46:31])) begin
            r.sat = 1'b1;
            r.val = 32'h8000_0000;
        end
        return r;
    endfunction

    // clip a 33-bit signed sum into the 32-bit range
    function automatic sat_t clip33(input logic [32:0] v);
        sat_t r;
        r.sat = 1'b0;
        r.val = v[31:0];
        if (v[32] != v[31]) begin
            r.sat = 1'b1;
            r.val = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: src/smacc_qmul.sv
// Shared Q16.16 multiplier: registered 64-bit product, floor shift and saturation.
`default_nettype none

module smacc_qmul
    import smacc_pkg::*;
(
    input  wire logic              aclk,
    input  wire mul_ctrl_t         ctrl,
    input  wire logic [DATA_W-1:0] a,
    input  wire logic [DATA_W-1:0] b,
    output sat_t                   q
);

    logic signed [2*DATA_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= $signed(a) * $signed(b);
        end
    end

    // arithmetic shift by 16 is the floor toward minus infinity
    assign q = clip48(prod_reg[63:16]);

endmodule

`default_nettype wire

FILE: src/smacc_factor_ram.sv
// Factor matrix storage, one write and one registered read port.
`default_nettype none

module smacc_factor_ram
    import smacc_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               we,
    input  wire logic [FADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0]  wdata,
    input  wire logic               re,
    input  wire logic [FADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0]  rdata
);

    logic [DATA_W-1:0] mem [2**FADDR_W];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: src/smacc_accum_ram.sv
// Accumulated output matrix storage, one write and one registered read port.
`default_nettype none

module smacc_accum_ram
    import smacc_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               we,
    input  wire logic [AADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0]  wdata,
    input  wire logic               re,
    input  wire logic [AADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0]  rdata
);

    logic [DATA_W-1:0] mem [2**AADDR_W];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: src/sparse_mttkrp_accumulator_unit.sv
// Top level: sequencer, config registers and stream ports of the sparse MTTKRP accumulator.
// Flow: a load writes the factor RAM on acceptance; a read captures the accumulator entry,
//   then presents it; a clear zeroes one accumulator entry per cycle; a nonzero multiplies,
//   per column, the factors of the non-target modes, then adds into the accumulator entry.
// One word at a time; the single shared multiplier and the accumulator port serialise it.
// Reset: synchronous active-low aresetn; afterwards a pass zeroes all 16384 accumulator
//   entries while s_tready stays low. Config writes are taken throughout.
`default_nettype none

module sparse_mttkrp_accumulator_unit
    import smacc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [1:0] factor_mode, [11:2] row, [15:12] column, [47:16] data,
    // [57:48] idx0, [67:58] idx1, [77:68] idx2, [87:78] idx3
    input  wire logic [87:0] s_tdata,
    input  wire logic [1:0]  s_tuser,   // [1:0] opcode
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] read_data
    output logic [0:0]       m_tuser,   // [0] saturated
    // config port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    state_t state_reg, state_next;

    // config registers
    logic [2:0] num_modes_reg;
    logic [4:0] rank_reg;
    logic [1:0] target_mode_reg;

    // latched word
    opcode_t           op_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [COL_W-1:0]  col_in_reg;
    logic [DATA_W-1:0] data_reg;
    logic [ROW_W-1:0]  idx_reg [MAX_MODES];

    // sequencer state
    logic [COL_W:0]     col_reg;
    logic [MODE_W:0]    mode_reg;
    logic [DATA_W-1:0]  p_reg;
    logic               sat_reg;
    logic [DATA_W-1:0]  rdata_reg;
    logic [AADDR_W-1:0] clr_cnt_reg;
    logic               clr_op_reg;

    logic       accept;
    opcode_t    s_op;
    logic [2:0] nm;
    logic [4:0] nr;
    logic       cfg_wr;

    mul_ctrl_t         mul_ctrl;
    sat_t              mul_q;
    sat_t              acc_sum;
    logic [DATA_W-1:0] fac_rdata;
    logic [DATA_W-1:0] acc_rdata;

    logic               fac_we, fac_re, acc_we, acc_re;
    logic [FADDR_W-1:0] fac_waddr, fac_raddr;
    logic [AADDR_W-1:0] acc_waddr, acc_raddr, acc_tgt_addr;
    logic [DATA_W-1:0]  acc_wdata;

    assign s_op   = opcode_t'(s_tuser);
    assign accept = s_tvalid && s_tready;
    assign nm     = (num_modes_reg > 3'(MAX_MODES)) ? 3'(MAX_MODES) : num_modes_reg;
    assign nr     = (rank_reg > 5'(MAX_RANK)) ? 5'(MAX_RANK) : rank_reg;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    // config read mux
    always_comb begin
        prdata = '0;
        unique case (reg_index_t'(paddr[3:2]))
            REG_NUM_MODES:   prdata = {29'd0, num_modes_reg};
            REG_RANK:        prdata = {27'd0, rank_reg};
            REG_TARGET_MODE: prdata = {30'd0, target_mode_reg};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_modes_reg   <= 3'd3;
            rank_reg        <= 5'd16;
            target_mode_reg <= 2'd0;
        end else if (cfg_wr) begin
            unique case (reg_index_t'(paddr[3:2]))
                REG_NUM_MODES:   num_modes_reg   <= pwdata[2:0];
                REG_RANK:        rank_reg        <= pwdata[4:0];
                REG_TARGET_MODE: target_mode_reg <= pwdata[1:0];
                default:         ;
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (&clr_cnt_reg) state_next = clr_op_reg ? ST_OUT : ST_IDLE;
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_op)
                        OP_LOAD:  state_next = ST_OUT;
                        OP_PROC:  state_next = (s_tdata[47:16] == '0) ? ST_OUT : ST_COL;
                        OP_READ:  state_next = ST_RRD;
                        OP_CLEAR: state_next = ST_CLEAR;
                        default:  state_next = ST_OUT;
                    endcase
                end
            end
            ST_COL:  state_next = (col_reg == nr) ? ST_OUT : ST_MODE;
            ST_MODE: begin
                if (mode_reg >= nm) begin
                    state_next = ST_ARD;
                end else if (mode_reg[MODE_W-1:0] != target_mode_reg) begin
                    state_next = ST_FMUL;
                end
            end
            ST_FMUL: state_next = ST_FSAT;
            ST_FSAT: state_next = ST_MODE;
            ST_ARD:  state_next = ST_AWR;
            ST_AWR:  state_next = ST_COL;
            ST_RRD:  state_next = ST_RCAP;
            ST_RCAP: state_next = ST_OUT;
            ST_OUT:  if (m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign acc_tgt_addr = {idx_reg[target_mode_reg], col_reg[COL_W-1:0]};
    assign acc_sum      = clip33({acc_rdata[31], acc_rdata} + {p_reg[31], p_reg});

    // outputs and memory controls
    always_comb begin
        s_tready        = (state_reg == ST_IDLE);
        m_tvalid        = (state_reg == ST_OUT);
        mul_ctrl.mul_en = (state_reg == ST_FMUL);
        fac_we          = accept && (s_op == OP_LOAD);
        fac_waddr       = {s_tdata[1:0], s_tdata[11:2], s_tdata[15:12]};
        fac_re          = (state_reg == ST_MODE);
        fac_raddr       = {mode_reg[MODE_W-1:0], idx_reg[mode_reg[MODE_W-1:0]],
                           col_reg[COL_W-1:0]};
        acc_we          = (state_reg == ST_CLEAR) || (state_reg == ST_AWR);
        acc_waddr       = (state_reg == ST_CLEAR) ? clr_cnt_reg : acc_tgt_addr;
        acc_wdata       = (state_reg == ST_CLEAR) ? '0 : acc_sum.val;
        acc_re          = (state_reg == ST_ARD) || (state_reg == ST_RRD);
        acc_raddr       = (state_reg == ST_ARD) ? acc_tgt_addr : {row_reg, col_in_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            clr_op_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (accept) begin
                clr_op_reg <= (s_op == OP_CLEAR);
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_reg     <= s_op;
                    row_reg    <= s_tdata[11:2];
                    col_in_reg <= s_tdata[15:12];
                    data_reg   <= s_tdata[47:16];
                    idx_reg[0] <= s_tdata[57:48];
                    idx_reg[1] <= s_tdata[67:58];
                    idx_reg[2] <= s_tdata[77:68];
                    idx_reg[3] <= s_tdata[87:78];
                    sat_reg    <= 1'b0;
                    rdata_reg  <= '0;
                    col_reg    <= '0;
                end
            end
            ST_COL: begin
                p_reg    <= data_reg;
                mode_reg <= '0;
            end
            ST_MODE: begin
                if (mode_reg < nm && mode_reg[MODE_W-1:0] == target_mode_reg) begin
                    mode_reg <= mode_reg + 1'b1;
                end
            end
            ST_FSAT: begin
                p_reg    <= mul_q.val;
                sat_reg  <= sat_reg | mul_q.sat;
                mode_reg <= mode_reg + 1'b1;
            end
            ST_AWR: begin
                sat_reg <= sat_reg | acc_sum.sat;
                col_reg <= col_reg + 1'b1;
            end
            ST_RCAP: rdata_reg <= acc_rdata;
            default: ;
        endcase
    end

    assign m_tdata    = rdata_reg;
    assign m_tuser[0] = sat_reg;

    smacc_qmul u_qmul (
        .aclk (aclk),
        .ctrl (mul_ctrl),
        .a    (p_reg),
        .b    (fac_rdata),
        .q    (mul_q)
    );

    smacc_factor_ram u_factor_ram (
        .aclk  (aclk),
        .we    (fac_we),
        .waddr (fac_waddr),
        .wdata (s_tdata[47:16]),
        .re    (fac_re),
        .raddr (fac_raddr),
        .rdata (fac_rdata)
    );

    smacc_accum_ram u_accum_ram (
        .aclk  (aclk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .re    (acc_re),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    // one word in flight: never ready while a result is waiting
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while result pending");

    // only reads return data
    a_read_only_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && op_reg != OP_READ) |-> (m_tdata == '0))
        else $error("non-read word returned data");

    // only a processed nonzero can clip
    a_sat_proc_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && op_reg != OP_PROC) |-> !m_tuser[0])
        else $error("saturation flagged on non-process word");

    // column counter never passes the rank limit
    a_col_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MODE) |-> (col_reg < 5'(MAX_RANK)))
        else $error("column counter out of range");

endmodule

`default_nettype wire
